// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the EEPROM slave modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, idle while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/i2cee_pkg.sv -----
// Types and constants shared by the EEPROM slave modules.
package i2cee_pkg;

    localparam int TICKS_W = 16;
    localparam int ADDR_OUT_W = 4;
    localparam logic [3:0] CMD_DEVICE_CODE = 4'hA;

    // One result item; the last member sits in the lowest bits.
    typedef struct packed {
        logic                  write_strobe;
        logic [ADDR_OUT_W-1:0] current_address;
        logic                  busy_res;
        logic                  sda_release;
    } result_t;

endpackage

// ----- hdl/i2cee_mem.sv -----
// Byte storage of the EEPROM with per-entry valid bits and a registered read.
module i2cee_mem
    import i2cee_pkg::*;
#(
    parameter int MEM_DEPTH = 16,
    parameter int AW = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rd_data
);

    logic [7:0]           mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [7:0]           mem_q_reg;
    logic [7:0]           wdata_q_reg;
    logic                 bypass_reg;
    logic                 hit_reg;

    // Storage array and read port; no reset on the data itself.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (we)
            begin
                mem[waddr] <= wdata;
            end
            mem_q_reg   <= mem[raddr];
            wdata_q_reg <= wdata;
        end
    end

    // An entry never written reads as zero, and a same-cycle write is forwarded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            bypass_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            bypass_reg <= we && (waddr == raddr);
            hit_reg    <= valid_reg[raddr];
        end
    end

    assign rd_data = bypass_reg ? wdata_q_reg : (hit_reg ? mem_q_reg : 8'h00);

endmodule

// ----- hdl/i2cee_core.sv -----
// Bus sampling and slave protocol state machine of the EEPROM.
`include "assert_macros.svh"

module i2cee_core
    import i2cee_pkg::*;
#(
    parameter int MEM_DEPTH = 16,
    parameter int AW = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               scl_level,
    input  logic               sda_level,
    input  logic [TICKS_W-1:0] busy_ticks,
    input  logic [7:0]         rd_data,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [7:0]         mem_wdata,
    output logic [AW-1:0]      mem_raddr,
    output result_t            result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_RX_CMD,
        PH_ACK_CMD,
        PH_RX_ADDR,
        PH_ACK_ADDR,
        PH_RX_DATA,
        PH_ACK_WR,
        PH_WRPEND,
        PH_TX_DATA,
        PH_ACK_RD
    } phase_t;

    localparam int RECIP = (65536 + MEM_DEPTH - 1) / MEM_DEPTH;

    phase_t             phase_reg, phase_next;
    logic [3:0]         bit_cnt_reg, bit_cnt_next;
    logic [7:0]         shift_reg, shift_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [TICKS_W-1:0] countdown_reg, countdown_next;
    logic               last_scl_reg, last_sda_reg;
    logic               drive_reg, drive_next;

    logic [7:0]         shift_in;
    logic [3:0]         bit_cnt_inc;
    logic [2:0]         bit_cnt_dec;
    logic [23:0]        recip_prod;
    logic [7:0]         quot;
    logic [15:0]        quot_times_depth;
    logic [AW-1:0]      addr_mod;
    logic [AW-1:0]      addr_inc;
    logic               strobe;

    assign shift_in    = {shift_reg[6:0], last_sda_reg};
    assign bit_cnt_inc = bit_cnt_reg + 4'd1;
    assign bit_cnt_dec = bit_cnt_reg[2:0] - 3'd1;

    // Address byte modulo the depth: the reciprocal estimate is exact for 8-bit values.
    assign recip_prod       = 24'(shift_in) * 24'(RECIP);
    assign quot             = recip_prod[23:16];
    assign quot_times_depth = 16'(quot) * 16'(MEM_DEPTH);
    assign addr_mod         = AW'(16'(shift_in) - quot_times_depth);

    assign addr_inc = (addr_reg == AW'(MEM_DEPTH - 1)) ? '0 : addr_reg + AW'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        addr_next      = addr_reg;
        drive_next     = drive_reg;
        countdown_next = (countdown_reg != '0) ? countdown_reg - TICKS_W'(1) : countdown_reg;
        strobe         = 1'b0;

        if (last_scl_reg && scl_level && (sda_level != last_sda_reg))
        begin
            if (sda_level)
            begin
                // Stop condition: a pending data byte is committed here.
                if (phase_reg == PH_WRPEND)
                begin
                    strobe         = 1'b1;
                    countdown_next = busy_ticks;
                end
                phase_next = PH_IDLE;
            end
            else if (countdown_next == '0)
            begin
                phase_next   = PH_START;
                bit_cnt_next = 4'd0;
                shift_next   = 8'h00;
            end
        end
        else if (last_scl_reg && !scl_level)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    drive_next = 1'b1;
                end
                PH_START:
                begin
                    drive_next = 1'b1;
                    phase_next = PH_RX_CMD;
                end
                PH_RX_CMD:
                begin
                    shift_next   = shift_in;
                    bit_cnt_next = bit_cnt_inc;
                    if (bit_cnt_inc == 4'd8)
                    begin
                        if (shift_in[7:4] == CMD_DEVICE_CODE)
                        begin
                            phase_next = PH_ACK_CMD;
                            drive_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_ACK_CMD:
                begin
                    if (shift_reg[0])
                    begin
                        phase_next   = PH_TX_DATA;
                        shift_next   = rd_data;
                        bit_cnt_next = 4'd7;
                        drive_next   = rd_data[7];
                    end
                    else
                    begin
                        drive_next   = 1'b1;
                        phase_next   = PH_RX_ADDR;
                        bit_cnt_next = 4'd0;
                        shift_next   = 8'h00;
                    end
                end
                PH_RX_ADDR:
                begin
                    shift_next   = shift_in;
                    bit_cnt_next = bit_cnt_inc;
                    if (bit_cnt_inc == 4'd8)
                    begin
                        drive_next = 1'b0;
                        phase_next = PH_ACK_ADDR;
                        addr_next  = addr_mod;
                    end
                end
                PH_ACK_ADDR:
                begin
                    drive_next   = 1'b1;
                    phase_next   = PH_RX_DATA;
                    bit_cnt_next = 4'd0;
                    shift_next   = 8'h00;
                end
                PH_RX_DATA:
                begin
                    shift_next   = shift_in;
                    bit_cnt_next = bit_cnt_inc;
                    if (bit_cnt_inc == 4'd8)
                    begin
                        drive_next = 1'b0;
                        phase_next = PH_ACK_WR;
                    end
                end
                PH_ACK_WR:
                begin
                    drive_next = 1'b1;
                    phase_next = PH_WRPEND;
                end
                PH_WRPEND:
                begin
                    // Another data byte replaces the pending one; its first bit is here.
                    shift_next   = {7'd0, last_sda_reg};
                    bit_cnt_next = 4'd1;
                    phase_next   = PH_RX_DATA;
                end
                PH_TX_DATA:
                begin
                    if (bit_cnt_reg == 4'd0)
                    begin
                        drive_next = 1'b1;
                        addr_next  = addr_inc;
                        phase_next = PH_ACK_RD;
                    end
                    else
                    begin
                        bit_cnt_next = {1'b0, bit_cnt_dec};
                        drive_next   = shift_reg[bit_cnt_dec];
                    end
                end
                PH_ACK_RD:
                begin
                    if (!last_sda_reg)
                    begin
                        phase_next   = PH_TX_DATA;
                        shift_next   = rd_data;
                        bit_cnt_next = 4'd7;
                        drive_next   = rd_data[7];
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    drive_next = 1'b1;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_cnt_reg   <= 4'd0;
            shift_reg     <= 8'h00;
            addr_reg      <= '0;
            countdown_reg <= '0;
            last_scl_reg  <= 1'b1;
            last_sda_reg  <= 1'b1;
            drive_reg     <= 1'b1;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            addr_reg      <= addr_next;
            countdown_reg <= countdown_next;
            last_scl_reg  <= scl_level;
            last_sda_reg  <= sda_level;
            drive_reg     <= drive_next;
        end
    end

    assign mem_we    = step && strobe;
    assign mem_waddr = addr_reg;
    assign mem_wdata = shift_reg;
    assign mem_raddr = addr_next;

    assign result.sda_release     = drive_next;
    assign result.busy_res        = (countdown_next != '0);
    assign result.current_address = ADDR_OUT_W'(addr_next);
    assign result.write_strobe    = strobe;

    `ASSERT_ALWAYS(a_bit_cnt_range, bit_cnt_reg <= 4'd8, "bit counter beyond one byte")
    `ASSERT_CLK(a_store_from_wrpend, mem_we |-> phase_reg == PH_WRPEND,
                "byte stored outside the pending-write phase")
    `ASSERT_CLK(a_ack_pulls_low, step && phase_reg == PH_ACK_ADDR |=> !$past(drive_reg),
                "address acknowledge not driven low")

endmodule

// ----- hdl/i2c_eeprom_slave.sv -----
// Top level of the sampled-bus I2C serial EEPROM slave.
//
//   channel  direction  payload (tdata, lowest bit first)
//   s_axis   in         scl_level, sda_level
//   m_axis   out        sda_release, busy_res, current_address[3:0], write_strobe
//   cfg      in         write_busy_ticks[15:0]
//
// A transfer on the input is worked through the protocol logic and lands in the
// output register on the same edge, so a new sample can be taken on every cycle
// while the output side keeps up.
// The output register holds a result until it is taken; the input is stalled only
// while that register is full and not being emptied in the same cycle.
// Reset is asynchronous and active low; it clears the protocol state and marks
// every storage byte as zero, so no clearing pass is needed afterwards.
// The read byte comes from a registered memory port whose address tracks the
// next word address, which keeps the memory read out of the per-sample path.
`include "assert_macros.svh"

module i2c_eeprom_slave
    import i2cee_pkg::*;
#(
    parameter int MEM_DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [0] scl_level, [1] sda_level, [7:2] zero

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // [0] sda_release, [1] busy_res,
                                    // [5:2] current_address, [6] write_strobe, [7] zero

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data   // write_busy_ticks
);

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [TICKS_W-1:0] busy_ticks_reg;
    logic               m_tvalid_reg;
    result_t            m_result_reg;

    logic               accept;
    result_t            result;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [7:0]         rd_data;

    // A sample is taken whenever the output register is free or being emptied.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // The busy-time register can always be written.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_ticks_reg <= TICKS_W'(1000);
        end
        else if (cfg_valid)
        begin
            busy_ticks_reg <= cfg_data;
        end
    end

    i2cee_core #(
        .MEM_DEPTH (MEM_DEPTH),
        .AW        (AW)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .scl_level  (s_tdata[0]),
        .sda_level  (s_tdata[1]),
        .busy_ticks (busy_ticks_reg),
        .rd_data    (rd_data),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .result     (result)
    );

    i2cee_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .AW        (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr   (mem_raddr),
        .rd_data (rd_data)
    );

    // Output register: loaded on every input transfer, emptied by the consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_result_reg};

    `ASSERT_CLK(a_stall_only_when_full, !s_tready |-> m_tvalid_reg,
                "input stalled with an empty output register")
    `ASSERT_CLK(a_store_sets_busy,
                accept && result.write_strobe |-> result.busy_res == (busy_ticks_reg != '0),
                "store did not start the busy period")
    `ASSERT_CLK(a_result_loaded, accept |=> m_tvalid_reg && m_tdata[6:0] == $past(result),
                "accepted sample did not reach the output register")

endmodule

// ----- dv/i2c_eeprom_slave_tb.sv -----
// Testbench for the sampled-bus I2C EEPROM slave, checked against a cycle-level shadow model.
`timescale 1ns / 100ps

module i2c_eeprom_slave_tb;
    import i2cee_pkg::*;

    localparam int MEM_WORDS = 16;

    // Cycles with no transfer on any channel before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;

    // Number of settings of the busy register the random part walks through.
    localparam int NUM_PHASES = 6;

    // Protocol states of the slave, in the order it walks through them.
    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_START,
        ST_CMD_BITS,
        ST_CMD_ACK,
        ST_ADDR_BITS,
        ST_ADDR_ACK,
        ST_DATA_BITS,
        ST_DATA_ACK,
        ST_WR_PENDING,
        ST_RD_BITS,
        ST_RD_ACK
    } bus_state_t;

    // Shadow copy of the slave. Every accepted bus sample is run through it, and the
    // response it predicts waits in a queue until the matching output transfer arrives.
    class i2cee_scoreboard;
        logic [15:0]  busy_ticks;
        bus_state_t   state;
        logic [3:0]   bit_cnt;
        logic [7:0]   shreg;
        logic [3:0]   word_addr;
        logic [15:0]  busy_cnt;
        logic         last_scl;
        logic         last_sda;
        logic         drive;
        logic [7:0]   mem [MEM_WORDS];
        result_t      pending_results [$];
        int unsigned  mismatches;
        int unsigned  samples_seen;

        function new();
            busy_ticks = 16'd1000;
            state = ST_IDLE;
            bit_cnt = '0;
            shreg = '0;
            word_addr = '0;
            busy_cnt = '0;
            last_scl = 1'b1;
            last_sda = 1'b1;
            drive = 1'b1;
            foreach (mem[i])
                mem[i] = '0;
            mismatches = 0;
            samples_seen = 0;
        endfunction

        // Shifts one received bit in and reports when a whole byte is complete.
        function bit shift_in(logic b);
            shreg = {shreg[6:0], b};
            bit_cnt = bit_cnt + 4'd1;
            return bit_cnt == 4'd8;
        endfunction

        // Puts the next outgoing bit on the line, most significant bit first.
        function void next_tx_bit();
            bit_cnt = {1'b0, 3'(bit_cnt - 4'd1)};
            drive = shreg[bit_cnt[2:0]];
        endfunction

        function void fetch_read_byte();
            shreg = mem[word_addr];
            bit_cnt = 4'd8;
            next_tx_bit();
        endfunction

        // Notes one accepted bus sample and queues the response it must cause.
        function void take_sample(logic scl, logic sda);
            result_t rsp;
            logic    strobe;
            logic    b;

            strobe = 1'b0;
            b = last_sda;
            samples_seen++;
            if (busy_cnt != 0)
                busy_cnt--;

            if (last_scl && scl && sda != last_sda)
            begin
                // SDA moved while SCL stayed high: a stop when rising, a start when falling.
                if (sda)
                begin
                    if (state == ST_WR_PENDING)
                    begin
                        mem[word_addr] = shreg;
                        busy_cnt = busy_ticks;
                        strobe = 1'b1;
                    end
                    state = ST_IDLE;
                end
                else if (busy_cnt == 0)
                begin
                    state = ST_START;
                    bit_cnt = '0;
                    shreg = '0;
                end
            end
            else if (last_scl && !scl)
            begin
                // SCL falling edge; the bit is the level held while SCL was high.
                case (state)
                    ST_IDLE:
                        drive = 1'b1;
                    ST_START:
                    begin
                        drive = 1'b1;
                        state = ST_CMD_BITS;
                    end
                    ST_CMD_BITS:
                        if (shift_in(b))
                        begin
                            if (shreg[7:4] == CMD_DEVICE_CODE)
                            begin
                                state = ST_CMD_ACK;
                                drive = 1'b0;
                            end
                            else
                                state = ST_IDLE;
                        end
                    ST_CMD_ACK:
                    begin
                        drive = 1'b1;
                        if (shreg[0])
                        begin
                            state = ST_RD_BITS;
                            fetch_read_byte();
                        end
                        else
                        begin
                            state = ST_ADDR_BITS;
                            bit_cnt = '0;
                            shreg = '0;
                        end
                    end
                    ST_ADDR_BITS:
                        if (shift_in(b))
                        begin
                            drive = 1'b0;
                            state = ST_ADDR_ACK;
                            word_addr = 4'(shreg % MEM_WORDS);
                        end
                    ST_ADDR_ACK:
                    begin
                        drive = 1'b1;
                        state = ST_DATA_BITS;
                        bit_cnt = '0;
                        shreg = '0;
                    end
                    ST_DATA_BITS:
                        if (shift_in(b))
                        begin
                            drive = 1'b0;
                            state = ST_DATA_ACK;
                        end
                    ST_DATA_ACK:
                    begin
                        drive = 1'b1;
                        state = ST_WR_PENDING;
                    end
                    ST_WR_PENDING:
                    begin
                        // Another data byte begins and replaces the pending one.
                        shreg = {7'b0, b};
                        bit_cnt = 4'd1;
                        state = ST_DATA_BITS;
                    end
                    ST_RD_BITS:
                        if (bit_cnt == 0)
                        begin
                            drive = 1'b1;
                            word_addr = 4'((word_addr + 1) % MEM_WORDS);
                            state = ST_RD_ACK;
                        end
                        else
                            next_tx_bit();
                    ST_RD_ACK:
                        if (!b)
                        begin
                            state = ST_RD_BITS;
                            fetch_read_byte();
                        end
                        else
                            state = ST_IDLE;
                    default:
                    begin
                        drive = 1'b1;
                        state = ST_IDLE;
                    end
                endcase
            end

            last_scl = scl;
            last_sda = sda;

            rsp.sda_release = drive;
            rsp.busy_res = (busy_cnt != 0);
            rsp.current_address = word_addr;
            rsp.write_strobe = strobe;
            pending_results.push_back(rsp);
        endfunction

        // Compares one output transfer with the oldest predicted response.
        function void check_result(logic [7:0] data);
            result_t got;
            result_t want;

            got = result_t'(data[6:0]);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected output transfer, data %h", $realtime, data);
                return;
            end
            want = pending_results.pop_front();
            if (got.sda_release !== want.sda_release || got.busy_res !== want.busy_res ||
                got.current_address !== want.current_address ||
                got.write_strobe !== want.write_strobe)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: rel/busy/addr/strb expected %b/%b/%0d/%b, got %b/%b/%0d/%b",
                             $realtime, want.sda_release, want.busy_res,
                             want.current_address, want.write_strobe, got.sda_release,
                             got.busy_res, got.current_address, got.write_strobe);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;     // [0] scl_level, [1] sda_level, [7:2] zero
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;     // [0] sda_release, [1] busy_res, [5:2] current_address,
                               // [6] write_strobe, [7] zero
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;    // write_busy_ticks

    // Chance, in percent, that the sender skips a cycle or the receiver stalls one.
    int unsigned  send_gap_pct;
    int unsigned  stall_pct;
    int unsigned  quiet_cycles;

    i2cee_scoreboard sb;

    i2c_eeprom_slave #(
        .MEM_DEPTH (MEM_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The receiver stalls at random; the rate follows the current idling mode.
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Every output transfer is checked on the edge where it happens.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one bus sample, waits for its transfer, and hands it to the scoreboard.
    task automatic send_sample(input logic scl, input logic sda);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, sda, scl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_sample(scl, sda);
    endtask

    // One SCL period. The master bit is wired-AND with what the slave drives, so
    // a released master bit reads back the slave's acknowledge or data.
    task automatic bus_bit(input logic m);
        int unsigned lo_len;
        int unsigned hi_len;

        lo_len = $urandom_range(1, 3);
        hi_len = $urandom_range(1, 2);
        repeat (lo_len)
            send_sample(1'b0, m & sb.drive);
        repeat (hi_len)
            send_sample(1'b1, m & sb.drive);
    endtask

    // Start, or repeated start: SDA released with SCL low, SCL up, then SDA down.
    task automatic bus_start();
        send_sample(1'b0, sb.drive);
        send_sample(1'b1, sb.drive);
        send_sample(1'b1, 1'b0);
    endtask

    task automatic bus_stop();
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, sb.drive);
    endtask

    // A byte from the master followed by the slave's acknowledge slot.
    task automatic send_byte(input logic [7:0] b);
        for (int i = 7; i >= 0; i--)
            bus_bit(b[i]);
        bus_bit(1'b1);
    endtask

    // A byte from the slave followed by the master's acknowledge or not.
    task automatic fetch_byte(input bit ack);
        repeat (8)
            bus_bit(1'b1);
        bus_bit(!ack);
    endtask

    task automatic read_burst();
        int unsigned n;

        n = $urandom_range(1, 4);
        for (int i = 1; i <= n; i++)
            fetch_byte(i < n || $urandom_range(0, 9) == 0);
    endtask

    // One random bus transaction: mostly well-formed writes and reads with random
    // content, the rest foreign commands, broken transactions and raw noise.
    task automatic run_transaction();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  cmd;

        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            bus_start();
            send_byte({CMD_DEVICE_CODE, 3'($urandom), 1'b0});
            send_byte(8'($urandom));
            n = $urandom_range(1, 3);
            repeat (n)
                send_byte(8'($urandom));
            pick = $urandom_range(0, 9);
            if (pick < 8)
                bus_stop();
            else if (pick == 8)
            begin
                bus_start();
                bus_stop();
            end
        end
        else if (pick < 60)
        begin
            // Random-address read: address set by a write header, then a repeated start.
            bus_start();
            send_byte({CMD_DEVICE_CODE, 3'($urandom), 1'b0});
            send_byte(8'($urandom));
            bus_start();
            send_byte({CMD_DEVICE_CODE, 3'($urandom), 1'b1});
            read_burst();
            bus_stop();
        end
        else if (pick < 70)
        begin
            bus_start();
            send_byte({CMD_DEVICE_CODE, 3'($urandom), 1'b1});
            read_burst();
            bus_stop();
        end
        else if (pick < 78)
        begin
            cmd = 8'($urandom);
            if (cmd[7:4] == CMD_DEVICE_CODE)
                cmd[7] = ~cmd[7];
            bus_start();
            send_byte(cmd);
            send_byte(8'($urandom));
            bus_stop();
        end
        else if (pick < 88)
        begin
            // Transaction cut short by a stop at a random bit.
            bus_start();
            n = $urandom_range(1, 24);
            repeat (n)
                bus_bit(1'($urandom));
            bus_stop();
        end
        else
        begin
            n = $urandom_range(4, 16);
            repeat (n)
                send_sample(1'($urandom), 1'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_busy_ticks(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.busy_ticks = value;
    endtask

    // Short directed run, encoded {sda, scl}: lines changing together in both
    // directions, start and stop, a command begun and cut off by a stop, and
    // SCL rising while SDA rises.
    logic [1:0] directed_seq [0:19] = '{
        2'b11, 2'b11, 2'b00, 2'b11, 2'b01, 2'b11, 2'b01, 2'b00, 2'b10, 2'b11,
        2'b10, 2'b00, 2'b01, 2'b00, 2'b01, 2'b11, 2'b10, 2'b00, 2'b11, 2'b11
    };

    int unsigned busy_setting [NUM_PHASES];
    int unsigned phase_budget [NUM_PHASES] = '{80, 70, 80, 80, 70, 40};

    initial
    begin
        int unsigned mark;

        sb = new();
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h03;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        quiet_cycles = 0;
        send_gap_pct = 6;
        stall_pct = 71;

        // Zero means never busy; the largest setting runs last.
        busy_setting = '{1, 0, 29, $urandom_range(2, 400), $urandom_range(400, 1500), 65535};

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs on the busy setting left by reset.
        foreach (directed_seq[i])
            send_sample(directed_seq[i][0], directed_seq[i][1]);
        s_tvalid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Idling: sender rarely and receiver often, then the reverse, then none.
            if (p < 2)
            begin
                send_gap_pct = 6;
                stall_pct = 71;
            end
            else if (p < 4)
            begin
                send_gap_pct = 71;
                stall_pct = 6;
            end
            else
            begin
                send_gap_pct = 0;
                stall_pct = 0;
            end

            // Every sample causes a response, so the slave is idle once all are in.
            wait_drained();
            write_busy_ticks(16'(busy_setting[p]));

            mark = sb.samples_seen;
            while (sb.samples_seen - mark < phase_budget[p])
                run_transaction();
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (8)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/i2cee_pkg.sv
hdl/i2cee_mem.sv
hdl/i2cee_core.sv
hdl/i2c_eeprom_slave.sv
dv/i2c_eeprom_slave_tb.sv
